### hdl/frs_pkg.sv
package frs_pkg;

  localparam int DIST_W  = 24;
  localparam int APER_W  = 16;
  localparam int POS_W   = 32;
  localparam int LIM_W   = 24;
  localparam int ISO_W   = 19;
  localparam int SHUT_W  = 32;
  localparam int MM_W    = 20;
  localparam int FRAC_W  = 4;

  localparam int IN_DATA_W  = 216;
  localparam int OUT_DATA_W = 176;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] STATUS_POINT = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_MISS  = 2'd2;

  localparam logic [5:0] RESULT_CAP = 6'd32;

  // lowest member last, so the packed layout matches tdata from bit 0 up
  typedef struct packed {
    logic [SHUT_W-1:0]        shutter;
    logic [ISO_W-1:0]         iso;
    logic [LIM_W-1:0]         far_lim;
    logic [LIM_W-1:0]         near_lim;
    logic signed [POS_W-1:0]  position;
    logic [APER_W-1:0]        aperture;
    logic [DIST_W-1:0]        distance;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### hdl/frs_ram.sv
module frs_ram
  import frs_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/focus_range_selector.sv
// Load item: lands at the end of the table, or each stored point with a greater near
//   limit is first shifted up one place; a full table drops it.
// Query item: accepted, points scanned through the first covering point, then each
//   passing point emitted until one ends the table or hits the cap, or a status item
//   emitted instead; output stalls hold the query; one item at a time.
// Reset clears the point count and the near/far bounds; table RAM is not cleared.
module focus_range_selector
  import frs_pkg::*;
#(
  parameter int ENTRIES = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // focus_distance, aperture, focus_position, near_limit, far_limit, iso_value,
  // shutter_speed, query_near, query_far
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // func
  input  logic [0:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // out_focus_distance, out_aperture, out_focus_position, out_near_limit,
  // out_far_limit, out_iso, out_shutter
  output logic [OUT_DATA_W-1:0] m_tdata,
  // status
  output logic [1:0]            m_tuser,
  output logic                  m_tlast
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    IDLE,
    INS,
    Q_SCAN,
    Q_NEXT,
    Q_LOOK,
    Q_STAT
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic [MM_W-1:0]    least_near;
  logic [MM_W-1:0]    greatest_far;
  entry_t             nw;
  entry_t             pend;
  entry_t             out_entry;
  logic [CW-1:0]      pos;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      pidx;
  logic [5:0]         n;
  logic [LIM_W-1:0]   nt16;
  logic [LIM_W-1:0]   ft16;
  logic [1:0]         stat;

  entry_t             s_ent;
  entry_t             rd;
  logic [MM_W-1:0]    q_near;
  logic [MM_W-1:0]    q_far;
  logic [MM_W-1:0]    near_tgt;
  logic [MM_W-1:0]    far_tgt;
  logic               in_acc;
  logic               out_free;
  logic               emit;
  logic               full;
  logic               place;
  logic               covers;
  logic               pass;
  logic               final_pt;
  logic [CW-1:0]      cnt_m1;
  logic [CW-1:0]      pos_m2;
  logic [CW-1:0]      idx_p1;
  logic [CW-1:0]      pidx_p1;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  entry_t             ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;

  assign s_ent    = entry_t'(s_tdata[ENTRY_W-1:0]);
  assign q_near   = s_tdata[ENTRY_W +: MM_W];
  assign q_far    = s_tdata[ENTRY_W + MM_W +: MM_W];
  assign near_tgt = (q_near > least_near) ? q_near : least_near;
  assign far_tgt  = (q_far < greatest_far) ? q_far : greatest_far;

  assign s_tready = (state == IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign full     = (count == CW'(ENTRIES));

  assign cnt_m1  = count - CW'(1);
  assign pos_m2  = pos - CW'(2);
  assign idx_p1  = idx + CW'(1);
  assign pidx_p1 = pidx + CW'(1);

  // insertion stops once the point below is not greater (ties keep load order)
  assign place    = (pos == '0) || !(rd.near_lim > nw.near_lim);
  assign covers   = (rd.near_lim <= nt16) && (rd.far_lim >= nt16);
  assign pass     = (rd.far_lim >= nt16) && (rd.near_lim <= ft16);
  assign final_pt = (n == RESULT_CAP) || (pidx_p1 == count);

  // a new item is loaded into the output register this cycle
  assign emit = out_free && ((state == Q_NEXT && final_pt) || state == Q_LOOK ||
                             state == Q_STAT);

  assign m_tdata = {(OUT_DATA_W - ENTRY_W)'(0), out_entry};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos[AW-1:0];
    ram_wdata = nw;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state)
      IDLE: begin
        if (in_acc && count != '0) begin
          if (s_tuser[0] == FUNC_LOAD && !full) begin
            ram_re    = 1'b1;
            ram_raddr = cnt_m1[AW-1:0];
          end else if (s_tuser[0] == FUNC_QUERY) begin
            ram_re = 1'b1;
          end
        end
      end
      INS: begin
        ram_we = 1'b1;
        if (!place) begin
          ram_wdata = rd;
          if (pos > CW'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = pos_m2[AW-1:0];
          end
        end
      end
      Q_SCAN: begin
        if (!covers && idx_p1 != count) begin
          ram_re    = 1'b1;
          ram_raddr = idx_p1[AW-1:0];
        end
      end
      Q_NEXT: begin
        if (!final_pt) begin
          ram_re    = 1'b1;
          ram_raddr = pidx_p1[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  frs_ram #(
    .DEPTH (ENTRIES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      count        <= '0;
      least_near   <= '0;
      greatest_far <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !emit) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_acc) begin
            if (s_tuser[0] == FUNC_LOAD) begin
              if (!full) begin
                nw    <= s_ent;
                pos   <= count;
                state <= INS;
                // zero bound means unset
                if (least_near == '0 || {least_near, FRAC_W'(0)} > s_ent.near_lim) begin
                  least_near <= s_ent.near_lim[LIM_W-1:FRAC_W];
                end
                if (greatest_far == '0 || {greatest_far, FRAC_W'(0)} < s_ent.far_lim) begin
                  greatest_far <= s_ent.far_lim[LIM_W-1:FRAC_W];
                end
              end
            end else begin
              nt16 <= {near_tgt, FRAC_W'(0)};
              ft16 <= {far_tgt, FRAC_W'(0)};
              idx  <= '0;
              if (count == '0) begin
                stat  <= STATUS_EMPTY;
                state <= Q_STAT;
              end else begin
                state <= Q_SCAN;
              end
            end
          end
        end
        INS: begin
          if (place) begin
            count <= count + CW'(1);
            state <= IDLE;
          end else begin
            pos <= pos - CW'(1);
          end
        end
        Q_SCAN: begin
          if (covers) begin
            if (rd.near_lim <= ft16) begin
              pend  <= rd;
              pidx  <= idx;
              n     <= 6'd1;
              state <= Q_NEXT;
            end else begin
              stat  <= STATUS_MISS;
              state <= Q_STAT;
            end
          end else if (idx_p1 == count) begin
            stat  <= STATUS_MISS;
            state <= Q_STAT;
          end else begin
            idx <= idx_p1;
          end
        end
        Q_NEXT: begin
          if (final_pt) begin
            if (out_free) begin
              m_tvalid  <= 1'b1;
              m_tuser   <= STATUS_POINT;
              m_tlast   <= 1'b1;
              out_entry <= pend;
              state     <= IDLE;
            end
          end else begin
            state <= Q_LOOK;
          end
        end
        Q_LOOK: begin
          // the held point is last unless the one after it still passes
          if (out_free) begin
            m_tvalid  <= 1'b1;
            m_tuser   <= STATUS_POINT;
            m_tlast   <= !pass;
            out_entry <= pend;
            if (pass) begin
              pend  <= rd;
              pidx  <= pidx_p1;
              n     <= n + 6'd1;
              state <= Q_NEXT;
            end else begin
              state <= IDLE;
            end
          end
        end
        Q_STAT: begin
          if (out_free) begin
            m_tvalid  <= 1'b1;
            m_tuser   <= stat;
            m_tlast   <= 1'b1;
            out_entry <= '0;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/frs_checker.sv
module frs_checker
  import frs_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [0:0]            s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [1:0]            m_tuser,
  input logic                  m_tlast
);

  // status items close the query
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != STATUS_POINT |-> m_tlast)
    else $error("status item without tlast");

  // status items carry no point
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != STATUS_POINT |-> m_tdata == '0)
    else $error("status item with nonzero payload");

  // a load never produces an item
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[0] == FUNC_LOAD |=> !$rose(m_tvalid))
    else $error("item emitted after a load");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled output item changed");

endmodule

bind focus_range_selector frs_checker u_frs_checker (.*);
